// ===== design/login_packet_framer_crc16_macros.svh =====
// Assertion macros for the login frame builder.
// Used by the top level only; expects clk and rst in scope.
`ifndef LOGIN_PACKET_FRAMER_CRC16_MACROS_SVH
`define LOGIN_PACKET_FRAMER_CRC16_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lpf_pkg.sv =====
// Shared types and constants for the login frame builder.
// No dependencies.
package lpf_pkg;

  localparam int unsigned IdW    = 64;
  localparam int unsigned SeqW   = 16;
  localparam int unsigned InW    = IdW + SeqW;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned IdxW   = 5;

  // Frame byte positions
  localparam logic [IdxW-1:0] PosLen    = 5'd2;
  localparam logic [IdxW-1:0] PosProto  = 5'd3;
  localparam logic [IdxW-1:0] PosSeqLo  = 5'd13;
  localparam logic [IdxW-1:0] PosLast   = 5'd17;

  // Fixed frame bytes
  localparam logic [ByteW-1:0] SyncByte  = 8'h78;
  localparam logic [ByteW-1:0] LenByte   = 8'h0d;
  localparam logic [ByteW-1:0] StopCr    = 8'h0d;
  localparam logic [ByteW-1:0] StopLf    = 8'h0a;
  localparam logic [ByteW-1:0] ProtoRst  = 8'h01;

  // CRC-16/X.25
  localparam logic [CrcW-1:0] CrcInit   = 16'hffff;
  localparam logic [CrcW-1:0] CrcPoly   = 16'h8408;

  // Request held between input register and serializer
  typedef struct packed {
    logic            valid;
    logic [IdW-1:0]  id;
    logic [SeqW-1:0] seq;
  } lpf_item_t;

endpackage

// ===== design/lpf_in_reg.sv =====
// Input holding register for one login request.
// Depends on lpf_pkg.
module lpf_in_reg import lpf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [InW-1:0] s_tdata,   // [63:0] terminal_id, [79:64] sequence_number
  output lpf_item_t      item,
  input  logic           take
);

  lpf_item_t held;

  assign s_tready = !held.valid;
  assign item     = held;

  // Capture one word, release it when the serializer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held.valid <= 1'b1;
      held.id    <= s_tdata[IdW-1:0];
      held.seq   <= s_tdata[InW-1:IdW];
    end else if (take) begin
      held.valid <= 1'b0;
    end
  end

endmodule

// ===== design/lpf_serializer.sv =====
// Frame serializer: emits 18 bytes per request, running CRC-16/X.25 on the fly.
// Depends on lpf_pkg.
module lpf_serializer import lpf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [ByteW-1:0] proto,
  input  lpf_item_t        item,
  output logic             take,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [ByteW-1:0] m_tdata,   // [7:0] frame_byte
  output logic             m_tlast    // last_byte
);

  // One byte of the reflected CRC, eight bit steps
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] c,
                                               input logic [ByteW-1:0] d);
    logic [CrcW-1:0] r;
    r = c ^ {{(CrcW-ByteW){1'b0}}, d};
    for (int b = 0; b < ByteW; b++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  logic [IdxW-1:0]  idx;
  logic [IdxW-1:0]  idx_next;
  logic [ByteW-1:0] proto_q;
  logic [IdW-1:0]   id_q;
  logic [SeqW-1:0]  seq_q;
  logic [CrcW-1:0]  crc;
  logic [ByteW-1:0] byte_next;
  logic             adv;
  logic             cont;

  assign adv      = !m_tvalid || m_tready;
  assign cont     = m_tvalid && (idx != PosLast);
  assign take     = adv && !cont && item.valid;
  assign idx_next = idx + 5'd1;

  // Byte that follows the one in the output register
  always_comb begin
    unique case (idx_next)
      5'd0, 5'd1: byte_next = SyncByte;
      5'd2:       byte_next = LenByte;
      5'd3:       byte_next = proto_q;
      5'd4:       byte_next = id_q[63:56];
      5'd5:       byte_next = id_q[55:48];
      5'd6:       byte_next = id_q[47:40];
      5'd7:       byte_next = id_q[39:32];
      5'd8:       byte_next = id_q[31:24];
      5'd9:       byte_next = id_q[23:16];
      5'd10:      byte_next = id_q[15:8];
      5'd11:      byte_next = id_q[7:0];
      5'd12:      byte_next = seq_q[15:8];
      5'd13:      byte_next = seq_q[7:0];
      5'd14:      byte_next = ~crc[15:8];
      5'd15:      byte_next = ~crc[7:0];
      5'd16:      byte_next = StopCr;
      5'd17:      byte_next = StopLf;
      default:    byte_next = '0;
    endcase
  end

  // Output register, byte index and running CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      idx      <= '0;
    end else if (adv) begin
      if (cont) begin
        idx     <= idx_next;
        m_tdata <= byte_next;
        m_tlast <= (idx_next == PosLast);
        if (idx_next >= PosLen && idx_next <= PosSeqLo) begin
          crc <= crc_byte(crc, byte_next);
        end
      end else if (item.valid) begin
        m_tvalid <= 1'b1;
        m_tlast  <= 1'b0;
        idx      <= '0;
        m_tdata  <= SyncByte;
        crc      <= CrcInit;
        proto_q  <= proto;
        id_q     <= item.id;
        seq_q    <= item.seq;
      end else begin
        m_tvalid <= 1'b0;
        m_tlast  <= 1'b0;
      end
    end
  end

endmodule

// ===== design/login_packet_framer_crc16.sv =====
// Channel  | Dir | Payload
// s_       | in  | tdata[63:0] terminal_id, tdata[79:64] sequence_number
// m_       | out | tdata[7:0] frame_byte, tlast last_byte
// cfg_     | in  | data[7:0] protocol_number
// Each request gives 18 output words, one per cycle while m_tready is high,
// so a request occupies the output register until its last byte is taken; the
// byte serializer sets the rate. First byte appears the cycle after it takes a word.
// A second request is held in the input register while a frame is being sent.
// Synchronous active-high rst clears valids; protocol_number resets to 0x01.
// Top level of the login frame builder: config register plus two stages.
// Depends on lpf_pkg, lpf_in_reg, lpf_serializer and the macros header.
`include "login_packet_framer_crc16_macros.svh"

module login_packet_framer_crc16 import lpf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [InW-1:0]   s_tdata,   // [63:0] terminal_id, [79:64] sequence_number
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [ByteW-1:0] m_tdata,   // [7:0] frame_byte
  output logic             m_tlast,   // last_byte
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [ByteW-1:0] cfg_data   // [7:0] protocol_number
);

  logic [ByteW-1:0] proto;
  lpf_item_t        item;
  logic             take;

  // Protocol number register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      proto <= ProtoRst;
    end else if (cfg_valid && cfg_ready) begin
      proto <= cfg_data;
    end
  end

  lpf_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .item     (item),
    .take     (take)
  );

  lpf_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .proto    (proto),
    .item     (item),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Checks
  `LPF_ASSERT_IMP(a_last_valid, m_tlast, m_tvalid, "tlast without tvalid")
  `LPF_ASSERT_NXT(a_frame_cont, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap in frame")
  `LPF_ASSERT_NXT(a_in_hold, s_tvalid && s_tready, !s_tready, "input register overrun")
  `LPF_ASSERT_IMP(a_take_held, take, item.valid && !s_tready, "take with empty input register")

endmodule
